// File: hdl/rmsd_pkg.sv
// Shared widths, state, command and status types for the running mean / std-dev unit.
package rmsd_pkg;

    localparam int MEAN_W  = 32;
    localparam int MSQ_W   = 47;
    localparam int STD_W   = 32;
    localparam int TOTAL_W = 24;
    localparam int MUL_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int VAR_W   = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MUL_MEAN,
        ST_SUM_MEAN,
        ST_ACC_LO,
        ST_ACC_HI,
        ST_ACC_SQ,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_COMMIT,
        ST_MUL_VAR,
        ST_SQRT_START,
        ST_SQRT_RUN,
        ST_PUBLISH
    } rmsd_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_MUL_MEAN,
        OP_SUM_MEAN,
        OP_ACC_LO,
        OP_ACC_HI,
        OP_ACC_SQ,
        OP_DIV_START,
        OP_COMMIT,
        OP_MUL_VAR,
        OP_SQRT_START,
        OP_PUBLISH
    } rmsd_op_t;

    typedef struct packed {
        rmsd_op_t op;
    } rmsd_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic out_full;
    } rmsd_status_t;

endpackage

// File: hdl/rmsd_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module rmsd_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quotient,
    output logic             busy
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   trial;
    logic             fit;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        fit      = (trial >= {1'b0, den_reg});
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
            rem_next = '0;
            den_next = den;
            quo_next = num;
        end
        else if (cnt_reg != '0)
        begin
            rem_next = fit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fit};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign busy     = (cnt_reg != '0);

endmodule

// File: hdl/rmsd_sqrt.sv
// Digit-serial integer square root, one root bit per cycle.
module rmsd_sqrt #(
    parameter int IN_W = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [IN_W-1:0]   value,
    output logic [IN_W/2-1:0] root,
    output logic              busy
);

    localparam int OUT_W = IN_W / 2;
    localparam int CNT_W = $clog2(OUT_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IN_W-1:0]  val_reg, val_next;
    logic [OUT_W:0]   rem_reg, rem_next;
    logic [OUT_W-1:0] root_reg, root_next;
    logic [OUT_W+2:0] r2;
    logic [OUT_W+2:0] trial;
    logic             fit;

    always_comb
    begin
        r2        = {rem_reg, val_reg[IN_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        fit       = (r2 >= trial);
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(OUT_W);
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fit ? (OUT_W+1)'(r2 - trial) : r2[OUT_W:0];
            root_next = {root_reg[OUT_W-2:0], fit};
            val_next  = {val_reg[IN_W-3:0], 2'b00};
            cnt_next  = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign busy = (cnt_reg != '0);

endmodule

// File: hdl/rmsd_datapath.sv
// Datapath: statistics registers, shared multiplier, dividers, square root, output register.
module rmsd_datapath #(
    parameter int COUNT_WIDTH  = 24,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rmsd_pkg::rmsd_cmd_t           cmd,
    output rmsd_pkg::rmsd_status_t        status,
    input  logic [SAMPLE_WIDTH-1:0]       sample,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [rmsd_pkg::MEAN_W-1:0]   mean,
    output logic [rmsd_pkg::MSQ_W-1:0]    mean_of_squares,
    output logic [rmsd_pkg::STD_W-1:0]    std_dev,
    output logic [rmsd_pkg::TOTAL_W-1:0]  sample_total
);

    localparam int MEAN_W  = rmsd_pkg::MEAN_W;
    localparam int MSQ_W   = rmsd_pkg::MSQ_W;
    localparam int STD_W   = rmsd_pkg::STD_W;
    localparam int TOTAL_W = rmsd_pkg::TOTAL_W;
    localparam int MUL_W   = rmsd_pkg::MUL_W;
    localparam int FRAC_W  = rmsd_pkg::FRAC_W;
    localparam int VAR_W   = rmsd_pkg::VAR_W;
    localparam int HI_W    = MSQ_W - MUL_W;
    localparam int MNUM_W  = MEAN_W + COUNT_WIDTH + 1;
    localparam int SQ_W    = 2 * SAMPLE_WIDTH + FRAC_W;
    localparam int PROD_W  = MSQ_W + COUNT_WIDTH;
    localparam int SNUM_W  = ((PROD_W > SQ_W) ? PROD_W : SQ_W) + 1;

    logic [COUNT_WIDTH-1:0]  count_reg;
    logic [MEAN_W-1:0]       mean_reg;
    logic [MSQ_W-1:0]        msq_reg;
    logic [SAMPLE_WIDTH-1:0] x_reg;
    logic [COUNT_WIDTH-1:0]  n_reg;
    logic [2*MUL_W-1:0]      prod_reg;
    logic [MNUM_W-1:0]       mnum_reg;
    logic                    mneg_reg;
    logic [SNUM_W-1:0]       snum_reg;
    logic                    out_valid_reg;
    logic [MEAN_W-1:0]       out_mean_reg;
    logic [MSQ_W-1:0]        out_msq_reg;
    logic [STD_W-1:0]        out_std_reg;
    logic [TOTAL_W-1:0]      out_total_reg;

    logic [COUNT_WIDTH-1:0]  nm1;
    logic [SAMPLE_WIDTH-1:0] xmag;
    logic [MEAN_W-1:0]       amag;
    logic [MUL_W-1:0]        mul_a, mul_b;
    logic [2*MUL_W-1:0]      mul_p;
    logic [MNUM_W-1:0]       am, bm;
    logic [MNUM_W-1:0]       mnum_next;
    logic                    mneg_next;
    logic [MNUM_W-1:0]       mq;
    logic [SNUM_W-1:0]       sq;
    logic                    mbusy, sbusy, rbusy;
    logic [MEAN_W-1:0]       mean_sat;
    logic [MSQ_W-1:0]        msq_sat;
    logic [VAR_W-1:0]        msq32;
    logic [VAR_W-1:0]        var_val;
    logic [STD_W-1:0]        root;
    logic                    div_start, sqrt_start;

    assign nm1  = n_reg - COUNT_WIDTH'(1);
    assign xmag = x_reg[SAMPLE_WIDTH-1] ? (~x_reg + SAMPLE_WIDTH'(1)) : x_reg;
    assign amag = mean_reg[MEAN_W-1] ? (~mean_reg + MEAN_W'(1)) : mean_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            rmsd_pkg::OP_MUL_MEAN:
            begin
                mul_a = MUL_W'(amag);
                mul_b = MUL_W'(nm1);
            end
            rmsd_pkg::OP_SUM_MEAN:
            begin
                mul_a = msq_reg[MUL_W-1:0];
                mul_b = MUL_W'(nm1);
            end
            rmsd_pkg::OP_ACC_LO:
            begin
                mul_a = MUL_W'(msq_reg[MSQ_W-1 -: HI_W]);
                mul_b = MUL_W'(nm1);
            end
            rmsd_pkg::OP_ACC_HI:
            begin
                mul_a = MUL_W'(xmag);
                mul_b = MUL_W'(xmag);
            end
            rmsd_pkg::OP_MUL_VAR:
            begin
                mul_a = MUL_W'(amag);
                mul_b = MUL_W'(amag);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // sign-magnitude sum for the mean numerator, truncating toward zero later
    always_comb
    begin
        am = MNUM_W'(prod_reg);
        bm = MNUM_W'(xmag) << FRAC_W;
        if (mean_reg[MEAN_W-1] == x_reg[SAMPLE_WIDTH-1])
        begin
            mnum_next = am + bm;
            mneg_next = mean_reg[MEAN_W-1];
        end
        else if (am >= bm)
        begin
            mnum_next = am - bm;
            mneg_next = mean_reg[MEAN_W-1];
        end
        else
        begin
            mnum_next = bm - am;
            mneg_next = x_reg[SAMPLE_WIDTH-1];
        end
    end

    always_comb
    begin
        if (mneg_reg)
        begin
            mean_sat = (mq > MNUM_W'(64'h8000_0000)) ? 32'h8000_0000
                                                   : (~mq[MEAN_W-1:0] + MEAN_W'(1));
        end
        else
        begin
            mean_sat = (mq > MNUM_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mq[MEAN_W-1:0];
        end
        msq_sat = ((sq >> MSQ_W) != '0) ? '1 : sq[MSQ_W-1:0];
        msq32   = VAR_W'({msq_reg, FRAC_W'(0)});
        var_val = (msq32 > prod_reg) ? (msq32 - prod_reg) : '0;
    end

    assign div_start  = (cmd.op == rmsd_pkg::OP_DIV_START);
    assign sqrt_start = (cmd.op == rmsd_pkg::OP_SQRT_START);

    rmsd_div #(
        .NUM_W (MNUM_W),
        .DEN_W (COUNT_WIDTH)
    ) u_div_mean (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (mnum_reg),
        .den      (n_reg),
        .quotient (mq),
        .busy     (mbusy)
    );

    rmsd_div #(
        .NUM_W (SNUM_W),
        .DEN_W (COUNT_WIDTH)
    ) u_div_msq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (snum_reg),
        .den      (n_reg),
        .quotient (sq),
        .busy     (sbusy)
    );

    rmsd_sqrt #(
        .IN_W (VAR_W)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (var_val),
        .root  (root),
        .busy  (rbusy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            mean_reg      <= '0;
            msq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                rmsd_pkg::OP_CLEAR:
                begin
                    count_reg <= '0;
                    mean_reg  <= '0;
                    msq_reg   <= '0;
                end
                rmsd_pkg::OP_COMMIT:
                begin
                    count_reg <= n_reg;
                    mean_reg  <= mean_sat;
                    msq_reg   <= msq_sat;
                end
                default:
                begin
                end
            endcase
            if (cmd.op == rmsd_pkg::OP_PUBLISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (cmd.op)
            rmsd_pkg::OP_LOAD:
            begin
                x_reg <= sample;
                n_reg <= (count_reg != '1) ? (count_reg + COUNT_WIDTH'(1)) : count_reg;
            end
            rmsd_pkg::OP_SUM_MEAN:
            begin
                mnum_reg <= mnum_next;
                mneg_reg <= mneg_next;
            end
            rmsd_pkg::OP_ACC_LO:
            begin
                snum_reg <= SNUM_W'(prod_reg);
            end
            rmsd_pkg::OP_ACC_HI:
            begin
                snum_reg <= snum_reg + (SNUM_W'(prod_reg) << MUL_W);
            end
            rmsd_pkg::OP_ACC_SQ:
            begin
                snum_reg <= snum_reg + (SNUM_W'(prod_reg) << FRAC_W);
            end
            rmsd_pkg::OP_PUBLISH:
            begin
                out_mean_reg  <= mean_reg;
                out_msq_reg   <= msq_reg;
                out_std_reg   <= root;
                out_total_reg <= TOTAL_W'(count_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign status.div_busy  = mbusy | sbusy;
    assign status.sqrt_busy = rbusy;
    assign status.out_full  = out_valid_reg;

    assign out_valid       = out_valid_reg;
    assign mean            = out_mean_reg;
    assign mean_of_squares = out_msq_reg;
    assign std_dev         = out_std_reg;
    assign sample_total    = out_total_reg;

endmodule

// File: hdl/rmsd_ctrl.sv
// Controller: sequences load, multiply, divide, square root and publish per item; a clear item skips the divide.
module rmsd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   kind,
    output logic                   in_ready,
    input  logic                   out_ready,
    input  rmsd_pkg::rmsd_status_t status,
    output rmsd_pkg::rmsd_cmd_t    cmd
);

    rmsd_pkg::rmsd_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmsd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = rmsd_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            rmsd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = rmsd_pkg::OP_LOAD;
                    state_next = kind ? rmsd_pkg::ST_CLEAR : rmsd_pkg::ST_MUL_MEAN;
                end
            end
            rmsd_pkg::ST_CLEAR:
            begin
                cmd.op     = rmsd_pkg::OP_CLEAR;
                state_next = rmsd_pkg::ST_MUL_VAR;
            end
            rmsd_pkg::ST_MUL_MEAN:
            begin
                cmd.op     = rmsd_pkg::OP_MUL_MEAN;
                state_next = rmsd_pkg::ST_SUM_MEAN;
            end
            rmsd_pkg::ST_SUM_MEAN:
            begin
                cmd.op     = rmsd_pkg::OP_SUM_MEAN;
                state_next = rmsd_pkg::ST_ACC_LO;
            end
            rmsd_pkg::ST_ACC_LO:
            begin
                cmd.op     = rmsd_pkg::OP_ACC_LO;
                state_next = rmsd_pkg::ST_ACC_HI;
            end
            rmsd_pkg::ST_ACC_HI:
            begin
                cmd.op     = rmsd_pkg::OP_ACC_HI;
                state_next = rmsd_pkg::ST_ACC_SQ;
            end
            rmsd_pkg::ST_ACC_SQ:
            begin
                cmd.op     = rmsd_pkg::OP_ACC_SQ;
                state_next = rmsd_pkg::ST_DIV_START;
            end
            rmsd_pkg::ST_DIV_START:
            begin
                cmd.op     = rmsd_pkg::OP_DIV_START;
                state_next = rmsd_pkg::ST_DIV_RUN;
            end
            rmsd_pkg::ST_DIV_RUN:
            begin
                if (!status.div_busy)
                begin
                    state_next = rmsd_pkg::ST_COMMIT;
                end
            end
            rmsd_pkg::ST_COMMIT:
            begin
                cmd.op     = rmsd_pkg::OP_COMMIT;
                state_next = rmsd_pkg::ST_MUL_VAR;
            end
            rmsd_pkg::ST_MUL_VAR:
            begin
                cmd.op     = rmsd_pkg::OP_MUL_VAR;
                state_next = rmsd_pkg::ST_SQRT_START;
            end
            rmsd_pkg::ST_SQRT_START:
            begin
                cmd.op     = rmsd_pkg::OP_SQRT_START;
                state_next = rmsd_pkg::ST_SQRT_RUN;
            end
            rmsd_pkg::ST_SQRT_RUN:
            begin
                if (!status.sqrt_busy)
                begin
                    state_next = rmsd_pkg::ST_PUBLISH;
                end
            end
            rmsd_pkg::ST_PUBLISH:
            begin
                if (!status.out_full || out_ready)
                begin
                    cmd.op     = rmsd_pkg::OP_PUBLISH;
                    state_next = rmsd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmsd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/running_mean_stddev_unit.sv
// Top level of the running mean and standard deviation unit.
//
// Input channel (in_valid/in_ready): kind = 0 adds sample to the statistics,
// kind = 1 clears count, mean and mean of squares. Every item yields one result
// item on the output channel (out_valid/out_ready): mean (Q16.16), mean of
// squares (Q31.16), standard deviation (Q16.16) and the saturating sample count.
//
// One item is worked on at a time. The bit-serial divider on the mean of
// squares sets most of the time a sample takes from acceptance to out_valid;
// the 32-step square root and a shared 32x32 multiplier used over five steps
// add the rest. A clear goes through the square root unit.
//
// The result sits in an output register; a new item is accepted while it waits.
// If the receiver stalls, the next result holds in the unit until that register
// is taken. Reset zeroes all statistics and empties the output register.
module running_mean_stddev_unit #(
    parameter int COUNT_WIDTH  = 24,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 kind,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [rmsd_pkg::MEAN_W-1:0]   mean,
    output logic [rmsd_pkg::MSQ_W-1:0]           mean_of_squares,
    output logic [rmsd_pkg::STD_W-1:0]           std_dev,
    output logic [rmsd_pkg::TOTAL_W-1:0]         sample_total
);

    rmsd_pkg::rmsd_cmd_t    cmd;
    rmsd_pkg::rmsd_status_t status;

    rmsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rmsd_datapath #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .sample          (sample),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .mean            (mean),
        .mean_of_squares (mean_of_squares),
        .std_dev         (std_dev),
        .sample_total    (sample_total)
    );

endmodule

// File: hdl/rmsd_checker.sv
// Port-level assertions for the running mean / std-dev unit, bound to the top level.
module rmsd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [rmsd_pkg::MEAN_W-1:0]   mean,
    input logic [rmsd_pkg::MSQ_W-1:0]    mean_of_squares,
    input logic [rmsd_pkg::STD_W-1:0]    std_dev,
    input logic [rmsd_pkg::TOTAL_W-1:0]  sample_total
);

    // one item in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready still high after an item was accepted");

    // a result is only produced while an item is in flight
    a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && in_ready |=> !out_valid)
        else $error("result appeared with no item in flight");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("out_valid rose while idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mean)
            && $stable(mean_of_squares) && $stable(std_dev) && $stable(sample_total))
        else $error("stalled result item changed");

endmodule

bind running_mean_stddev_unit rmsd_checker u_rmsd_checker (.*);
